// ===== hdl/gtc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, register codes and types of the green tile classifier.
package gtc_pkg;

  localparam int COLOR_W    = 8;
  localparam int S_DATA_W   = 3 * COLOR_W;
  localparam int COUNT_W    = 17;
  localparam int CLASS_W    = 2;
  localparam int PCT_W      = 7;
  localparam int HUE_W      = 8;
  localparam int NUM_W      = 17;
  localparam int DEN_W      = COLOR_W + 1;
  localparam int DIV_STAGES = HUE_W;
  localparam int PROD_W     = COUNT_W + PCT_W + 1;

  localparam int M_CLASS_LSB  = 0;
  localparam int M_GREEN_LSB  = M_CLASS_LSB + CLASS_W;
  localparam int M_PIXEL_LSB  = M_GREEN_LSB + COUNT_W;
  localparam int M_FIELDS_W   = M_PIXEL_LSB + COUNT_W;
  localparam int M_DATA_W     = ((M_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int unsigned MAX_TILE_PIXELS_DEF = 65536;
  localparam int unsigned TALLY_CAP           = (1 << COUNT_W) - 1;

  localparam logic [HUE_W-1:0] HUE_WRAP  = 8'd180;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_PCT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_PCT   = 2'd3;

  localparam logic [HUE_W-1:0] HUE_LOW_RST   = 8'd20;
  localparam logic [HUE_W-1:0] HUE_HIGH_RST  = 8'd110;
  localparam logic [PCT_W-1:0] FIELD_PCT_RST = 7'd65;
  localparam logic [PCT_W-1:0] EDGE_PCT_RST  = 7'd50;

  localparam logic [CLASS_W-1:0] CLASS_NOT_FIELD = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_UNCERTAIN = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_FIELD     = 2'd2;

  typedef struct packed {
    logic [HUE_W-1:0] hue_low;
    logic [HUE_W-1:0] hue_high;
    logic [PCT_W-1:0] field_pct;
    logic [PCT_W-1:0] edge_pct;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] green;
    logic [COUNT_W-1:0] pixels;
  } tile_counts_t;

endpackage

// ===== hdl/gtc_front.sv =====
`timescale 1ns / 1ps
// Front end: pixel intake, pipelined hue divider, band test and tile tallies.
module gtc_front #(
  parameter int unsigned MAX_TILE_PIXELS = gtc_pkg::MAX_TILE_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gtc_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tlast,
  input  gtc_pkg::cfg_t                cfg,
  output logic                         push,
  output gtc_pkg::tile_counts_t        push_data,
  input  logic                         full
);
  import gtc_pkg::*;

  localparam int unsigned TALLY_LIM =
    (MAX_TILE_PIXELS > TALLY_CAP) ? TALLY_CAP : MAX_TILE_PIXELS;
  localparam logic [COUNT_W-1:0] TALLY_MAX = COUNT_W'(TALLY_LIM);

  logic [COLOR_W-1:0] b, g, r, mx, mn, d;
  logic signed [17:0] bs, gs, rs, ds, t_raw, t_adj, num_s;
  logic               r_max, g_max;

  logic [DIV_STAGES:0]  vld;
  logic [NUM_W-1:0]     rem       [0:DIV_STAGES];
  logic [DEN_W-1:0]     den       [0:DIV_STAGES];
  logic [HUE_W-1:0]     quo       [0:DIV_STAGES];
  logic                 last_flag [0:DIV_STAGES];

  logic                 adv, take, in_band;
  logic [HUE_W-1:0]     hue;
  logic [COUNT_W-1:0]   green_tally, pixel_tally, green_tally_next, pixel_tally_next;

  assign b = s_tdata[COLOR_W-1:0];
  assign g = s_tdata[2*COLOR_W-1:COLOR_W];
  assign r = s_tdata[3*COLOR_W-1:2*COLOR_W];

  always_comb begin
    r_max = (r >= g) && (r >= b);
    g_max = (g >= b);
    mx = r_max ? r : (g_max ? g : b);
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d  = mx - mn;
    bs = signed'({10'd0, b});
    gs = signed'({10'd0, g});
    rs = signed'({10'd0, r});
    ds = signed'({10'd0, d});
    if (r_max) begin
      t_raw = 18'sd30 * (gs - bs);
    end else if (g_max) begin
      t_raw = 18'sd60 * ds + 18'sd30 * (bs - rs);
    end else begin
      t_raw = 18'sd120 * ds + 18'sd30 * (rs - gs);
    end
    t_adj = (t_raw < 0) ? t_raw + 18'sd180 * ds : t_raw;
    num_s = (t_adj <<< 1) + ds;
  end

  assign take     = vld[DIV_STAGES] && adv;
  assign adv      = !(vld[DIV_STAGES] && last_flag[DIV_STAGES] && full);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STAGES-1:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]       <= num_s[NUM_W-1:0];
      den[0]       <= {d, 1'b0};
      quo[0]       <= '0;
      last_flag[0] <= s_tlast;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    logic [NUM_W-1:0] dsh;
    logic             ge;
    assign dsh = NUM_W'(den[k-1]) << (DIV_STAGES - k);
    assign ge  = rem[k-1] >= dsh;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]       <= ge ? rem[k-1] - dsh : rem[k-1];
        quo[k]       <= quo[k-1] | (HUE_W'(ge) << (DIV_STAGES - k));
        den[k]       <= den[k-1];
        last_flag[k] <= last_flag[k-1];
      end
    end
  end

  always_comb begin
    if (den[DIV_STAGES] == '0) begin
      hue = '0;
    end else if (quo[DIV_STAGES] >= HUE_WRAP) begin
      hue = quo[DIV_STAGES] - HUE_WRAP;
    end else begin
      hue = quo[DIV_STAGES];
    end
    in_band = (hue > cfg.hue_low) && (hue < cfg.hue_high);
    pixel_tally_next = (pixel_tally < TALLY_MAX) ? pixel_tally + 1'b1 : pixel_tally;
    green_tally_next = (in_band && (green_tally < TALLY_MAX)) ?
                       green_tally + 1'b1 : green_tally;
  end

  assign push             = take && last_flag[DIV_STAGES];
  assign push_data.green  = green_tally_next;
  assign push_data.pixels = pixel_tally_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      green_tally <= '0;
      pixel_tally <= '0;
    end else if (take) begin
      if (last_flag[DIV_STAGES]) begin
        green_tally <= '0;
        pixel_tally <= '0;
      end else begin
        green_tally <= green_tally_next;
        pixel_tally <= pixel_tally_next;
      end
    end
  end

endmodule

// ===== hdl/gtc_queue.sv =====
`timescale 1ns / 1ps
// Short queue of finished tile counts between front and back.
module gtc_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gtc_pkg::tile_counts_t push_data,
  output logic                  full,
  input  logic                  pop,
  output gtc_pkg::tile_counts_t pop_data,
  output logic                  not_empty
);
  import gtc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tile_counts_t       slots [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/gtc_back.sv =====
`timescale 1ns / 1ps
// Back end: share thresholds by cross multiplication and the result register.
module gtc_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gtc_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  gtc_pkg::tile_counts_t        q_data,
  output logic                         q_pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gtc_pkg::M_DATA_W-1:0] m_tdata
);
  import gtc_pkg::*;

  logic                 s1_vld, adv_out, adv1;
  logic [PROD_W-1:0]    prod_green, prod_field, prod_edge;
  tile_counts_t         s1_counts;
  logic [CLASS_W-1:0]   cls, out_class;
  tile_counts_t         out_counts;

  assign adv_out = !m_tvalid || m_tready;
  assign adv1    = !s1_vld || adv_out;
  assign q_pop   = q_valid && adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv1)    s1_vld   <= q_valid;
      if (adv_out) m_tvalid <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_counts  <= q_data;
      prod_green <= PROD_W'(q_data.green) * PROD_W'(PCT_SCALE);
      prod_field <= (PROD_W'(cfg.field_pct) + 1'b1) * PROD_W'(q_data.pixels);
      prod_edge  <= (PROD_W'(cfg.edge_pct) + 1'b1) * PROD_W'(q_data.pixels);
    end
  end

  always_comb begin
    if (prod_green >= prod_field) begin
      cls = CLASS_FIELD;
    end else if (prod_green >= prod_edge) begin
      cls = CLASS_UNCERTAIN;
    end else begin
      cls = CLASS_NOT_FIELD;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_class  <= cls;
      out_counts <= s1_counts;
    end
  end

  assign m_tdata = {(M_DATA_W - M_FIELDS_W)'(0), out_counts.pixels,
                    out_counts.green, out_class};

endmodule

// ===== hdl/green_tile_classifier.sv =====
`timescale 1ns / 1ps
// Green tile classifier top level: config registers, front, queue and back.
// Accepts one BGR pixel per clock while the result queue has room. Each pixel
// passes an input register and an eight-stage restoring divider that forms
// its 0..179 hue, so the tally counts a pixel once it leaves the last stage;
// the tile result then passes the queue slot, a multiply stage and the
// output register. Up to four finished tiles wait in the queue while
// the result side is stalled; input stalls only when the queue is full and a
// last pixel reaches the tally. Results keep tile order.
module green_tile_classifier #(
  parameter int unsigned MAX_TILE_PIXELS = gtc_pkg::MAX_TILE_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gtc_pkg::S_DATA_W-1:0]   s_tdata,   // blue, green, red
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gtc_pkg::M_DATA_W-1:0]   m_tdata,   // tile_class, green_count, pixel_count
  input  logic                           cfg_we,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gtc_pkg::*;

  cfg_t         cfg;
  logic         push, full, pop, not_empty;
  tile_counts_t push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_low   <= HUE_LOW_RST;
      cfg.hue_high  <= HUE_HIGH_RST;
      cfg.field_pct <= FIELD_PCT_RST;
      cfg.edge_pct  <= EDGE_PCT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUE_LOW:   cfg.hue_low   <= cfg_data[HUE_W-1:0];
        REG_HUE_HIGH:  cfg.hue_high  <= cfg_data[HUE_W-1:0];
        REG_FIELD_PCT: cfg.field_pct <= cfg_data[PCT_W-1:0];
        REG_EDGE_PCT:  cfg.edge_pct  <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  gtc_front #(
    .MAX_TILE_PIXELS(MAX_TILE_PIXELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  gtc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty)
  );

  gtc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (not_empty),
    .q_data   (pop_data),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== hdl/gtc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the classifier result stream, bound to the top level.
module gtc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [gtc_pkg::M_DATA_W-1:0] m_tdata
);
  import gtc_pkg::*;

  logic [CLASS_W-1:0] cls;
  logic [COUNT_W-1:0] grn, pix;

  assign cls = m_tdata[M_CLASS_LSB +: CLASS_W];
  assign grn = m_tdata[M_GREEN_LSB +: COUNT_W];
  assign pix = m_tdata[M_PIXEL_LSB +: COUNT_W];

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result word changed while stalled");

  a_nonempty_tile: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pix != '0)
    else $error("tile result with no pixels");

  a_green_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> grn <= pix)
    else $error("green count exceeds pixel count");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cls == CLASS_NOT_FIELD || cls == CLASS_UNCERTAIN || cls == CLASS_FIELD))
    else $error("undefined tile class");

endmodule

bind green_tile_classifier gtc_checker u_gtc_checker (.*);

// ===== tb/green_tile_checker.sv =====
`timescale 1ns / 1ps
// Checker for the green tile classifier: predicts each tile result and compares.
module green_tile_checker #(
  parameter int unsigned MAX_TILE_PIXELS = gtc_pkg::MAX_TILE_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [gtc_pkg::S_DATA_W-1:0]   s_tdata,   // blue, green, red
  input  logic                           s_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [gtc_pkg::M_DATA_W-1:0]   m_tdata,   // tile_class, green_count, pixel_count
  input  logic                           cfg_we,
  input  logic [gtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gtc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             tiles_checked,
  output int                             tiles_pending
);
  import gtc_pkg::*;

  localparam int unsigned TALLY_LIMIT =
    (MAX_TILE_PIXELS > TALLY_CAP) ? TALLY_CAP : MAX_TILE_PIXELS;

  typedef struct packed {
    logic [CLASS_W-1:0] tile_class;
    logic [COUNT_W-1:0] green_count;
    logic [COUNT_W-1:0] pixel_count;
  } tile_result_t;

  tile_result_t     tiles_due[$];
  logic [HUE_W-1:0] band_low;
  logic [HUE_W-1:0] band_high;
  logic [PCT_W-1:0] field_share;
  logic [PCT_W-1:0] edge_share;
  int unsigned      green_tally;
  int unsigned      pixel_tally;
  int               mismatches = 0;
  int               checked = 0;

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int unsigned hue_of_pixel(input logic [COLOR_W-1:0] b8,
                                               input logic [COLOR_W-1:0] g8,
                                               input logic [COLOR_W-1:0] r8);
    int b, g, r, mx, mn, d, t;
    int unsigned h;
    b = b8;
    g = g8;
    r = r8;
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) return 0;
    if (mx == r) t = 30 * (g - b);
    else if (mx == g) t = 60 * d + 30 * (b - r);
    else t = 120 * d + 30 * (r - g);
    if (t < 0) t += 180 * d;
    h = (2 * t + d) / (2 * d);
    if (h >= HUE_WRAP) h -= HUE_WRAP;
    return h;
  endfunction

  always @(posedge clk) begin : track
    tile_result_t want;
    int unsigned  hue;
    int unsigned  share;
    if (rst) begin
      band_low    = HUE_LOW_RST;
      band_high   = HUE_HIGH_RST;
      field_share = FIELD_PCT_RST;
      edge_share  = EDGE_PCT_RST;
      green_tally = 0;
      pixel_tally = 0;
      tiles_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HUE_LOW:   band_low = cfg_data;
          REG_HUE_HIGH:  band_high = cfg_data;
          REG_FIELD_PCT: field_share = cfg_data[PCT_W-1:0];
          REG_EDGE_PCT:  edge_share = cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (tiles_due.size() == 0) begin
          report($sformatf("result word %h with no tile pending", m_tdata));
        end else begin
          want = tiles_due.pop_front();
          if (m_tdata[M_CLASS_LSB +: CLASS_W] !== want.tile_class)
            report($sformatf("tile %0d class got %0d want %0d", checked,
                             m_tdata[M_CLASS_LSB +: CLASS_W], want.tile_class));
          if (m_tdata[M_GREEN_LSB +: COUNT_W] !== want.green_count)
            report($sformatf("tile %0d green_count got %0d want %0d", checked,
                             m_tdata[M_GREEN_LSB +: COUNT_W], want.green_count));
          if (m_tdata[M_PIXEL_LSB +: COUNT_W] !== want.pixel_count)
            report($sformatf("tile %0d pixel_count got %0d want %0d", checked,
                             m_tdata[M_PIXEL_LSB +: COUNT_W], want.pixel_count));
          if (m_tdata[M_DATA_W-1:M_FIELDS_W] !== '0)
            report($sformatf("tile %0d pad bits got %h want 0", checked,
                             m_tdata[M_DATA_W-1:M_FIELDS_W]));
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        hue = hue_of_pixel(s_tdata[0 +: COLOR_W], s_tdata[COLOR_W +: COLOR_W],
                           s_tdata[2*COLOR_W +: COLOR_W]);
        if (pixel_tally < TALLY_LIMIT) pixel_tally++;
        if (hue > band_low && hue < band_high && green_tally < TALLY_LIMIT) green_tally++;
        if (s_tlast) begin
          share = green_tally * PCT_SCALE / pixel_tally;
          if (share > field_share) want.tile_class = CLASS_FIELD;
          else if (share > edge_share) want.tile_class = CLASS_UNCERTAIN;
          else want.tile_class = CLASS_NOT_FIELD;
          want.green_count = COUNT_W'(green_tally);
          want.pixel_count = COUNT_W'(pixel_tally);
          tiles_due = {tiles_due, want};
          green_tally = 0;
          pixel_tally = 0;
        end
      end
    end
    fail_count    <= mismatches;
    tiles_checked <= checked;
    tiles_pending <= tiles_due.size();
  end

endmodule

// ===== tb/green_tile_classifier_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the green tile classifier: drives tiles and registers under varied pacing.
module green_tile_classifier_test;
  import gtc_pkg::*;

  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int IDLE_LIMIT      = 3000;
  localparam int PHASE_PIXELS    = 190;

  typedef enum {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] hue_low;
    logic [CFG_DATA_W-1:0] hue_high;
    logic [CFG_DATA_W-1:0] field_pct;
    logic [CFG_DATA_W-1:0] edge_pct;
  } reg_setting_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata;   // blue, green, red
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_DATA_W-1:0]   m_tdata;   // tile_class, green_count, pixel_count
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int           fail_count;
  int           tiles_checked;
  int           tiles_pending;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  bit           hold_start = 1'b0;
  int           pixels_sent = 0;
  reg_setting_t settings[8];

  green_tile_classifier dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  green_tile_checker tile_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .tiles_checked(tiles_checked), .tiles_pending(tiles_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle = 0;
      else idle++;
    end
    $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_pixel(input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] r, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r, g, b};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_random_tile(input int len);
    int bias;
    logic [COLOR_W-1:0] b, g, r;
    bias = $urandom_range(100);
    for (int i = 0; i < len; i++) begin
      r = COLOR_W'($urandom);
      g = COLOR_W'($urandom);
      b = COLOR_W'($urandom);
      case ($urandom_range(9))
        0: begin
          g = r;
          b = r;
        end
        1: begin
          case ($urandom_range(2))
            0: g = r;
            1: b = g;
            default: r = b;
          endcase
        end
        2: begin
          r = $urandom_range(1) ? 8'hFF : 8'h00;
          g = $urandom_range(1) ? 8'hFF : 8'h00;
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: ;
      endcase
      if ($urandom_range(99) < bias) begin
        g = COLOR_W'($urandom_range(255, 128));
        r = COLOR_W'($urandom_range(g / 2));
        b = COLOR_W'($urandom_range(g / 2));
      end
      send_pixel(b, g, r, i == len - 1);
    end
  endtask

  // hold input, wait out every pending tile and the pipeline behind it
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (tiles_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input reg_setting_t s);
    put_reg(REG_HUE_LOW, s.hue_low);
    put_reg(REG_HUE_HIGH, s.hue_high);
    put_reg(REG_FIELD_PCT, s.field_pct);
    put_reg(REG_EDGE_PCT, s.edge_pct);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SENDER:   begin send_idle_pct = 50; recv_stall_pct = 0;  end
      PACE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 50; end
      default:       begin send_idle_pct = 12; recv_stall_pct = 12; end
    endcase
  endtask

  initial begin : stimulus
    int phase_start;
    int lo;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_HUE_LOW;
    cfg_data  <= '0;
    settings[0] = '{8'd20, 8'd110, 8'd65, 8'd50};
    settings[1] = '{8'd0, 8'd255, 8'd100, 8'd0};
    settings[2] = '{8'd0, 8'd180, 8'd0, 8'd0};
    settings[3] = '{8'd100, 8'd101, 8'd50, 8'd50};
    settings[4] = '{8'd179, 8'd180, 8'd99, 8'd1};
    settings[5] = '{8'd40, 8'd90, 8'd200, 8'd127};
    settings[6] = '{8'd20, 8'd110, 8'd65, 8'd50};
    settings[7] = '{8'd10, 8'd170, 8'd100, 8'd100};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // primaries, greys, ties, hue wrap, band edges and a rounded half
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd170, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd85, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd60, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    drain();
    program_regs(reg_setting_t'{8'd0, 8'd255, 8'd0, 8'd0});
    send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    drain();
    program_regs(reg_setting_t'{8'd100, 8'd101, 8'd127, 8'd200});
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 6) begin
        lo = $urandom_range(179);
        settings[6].hue_low   = CFG_DATA_W'(lo);
        settings[6].hue_high  = CFG_DATA_W'($urandom_range(180, lo));
        settings[6].field_pct = CFG_DATA_W'($urandom_range(100));
        settings[6].edge_pct  = CFG_DATA_W'($urandom_range(100));
      end
      drain();
      program_regs(settings[phase]);
      set_pace(pace_t'(phase % 4));
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_PIXELS)
        send_random_tile(($urandom_range(9) == 0) ? $urandom_range(60, 13)
                                                   : $urandom_range(12, 1));
    end

    // stall the result side long enough to back up the input
    drain();
    set_pace(PACE_NONE);
    program_regs(settings[0]);
    hold_start = 1'b1;
    repeat (40) send_random_tile($urandom_range(3, 1));
    drain();

    $display("Run covered %0d pixels in %0d checked tiles over ten register settings",
             pixels_sent, tiles_checked);
    $display("and four pacing modes, plus a long result stall that backs up the input.");
    if (fail_count == 0 && tiles_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/gtc_pkg.sv
hdl/gtc_front.sv
hdl/gtc_queue.sv
hdl/gtc_back.sv
hdl/green_tile_classifier.sv
hdl/gtc_checker.sv
tb/green_tile_checker.sv
tb/green_tile_classifier_test.sv
